>>> design/texture_layer_blend_assert.svh
// Assertion macros for the texture layer blend pipeline.
`ifndef TEXTURE_LAYER_BLEND_ASSERT_SVH
`define TEXTURE_LAYER_BLEND_ASSERT_SVH

`ifndef ASSERT_OFF
`define TLB_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("tlb assertion failed");
`define TLB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlb assertion failed");
`else
`define TLB_ASSERT(lbl, clk, rst, prop)
`define TLB_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> design/tlb_pkg.sv
`default_nettype none
package tlb_pkg;

   localparam int FRAC_BITS   = 12;
   localparam int ONE         = 1 << FRAC_BITS;
   localparam int HALF        = 1 << (FRAC_BITS - 1);
   localparam int K_R         = (35 * ONE + 50) / 100;
   localparam int K_G         = (45 * ONE + 50) / 100;
   localparam int K_B         = (20 * ONE + 50) / 100;
   localparam int LANES       = 4;
   localparam int SCALAR_LANE = 3;

   // control_flags bit positions
   localparam int FL_NEG     = 0;
   localparam int FL_STENCIL = 1;
   localparam int FL_TOINT   = 2;
   localparam int FL_COLOR   = 3;
   localparam int FL_SCALAR  = 4;
   localparam int FL_ALPHA   = 5;
   localparam int FL_CIN     = 6;

   typedef logic signed [15:0] fix_type;
   typedef logic signed [39:0] wide_type;

   typedef enum logic [3:0] {
      MODE_MIX        = 4'd0,
      MODE_ADD        = 4'd1,
      MODE_MULTIPLY   = 4'd2,
      MODE_SUBTRACT   = 4'd3,
      MODE_SCREEN     = 4'd4,
      MODE_DIVIDE     = 4'd5,
      MODE_DIFFERENCE = 4'd6,
      MODE_DARKEN     = 4'd7,
      MODE_LIGHTEN    = 4'd8
   } mode_type;

   typedef enum logic [2:0] {
      CSR_BLEND_MODE    = 3'd0,
      CSR_CONTROL_FLAGS = 3'd1,
      CSR_COLOR_FACTOR  = 3'd2,
      CSR_VALUE_FACTOR  = 3'd3,
      CSR_DEFAULT_VALUE = 3'd4,
      CSR_DEFAULT_COLOR = 3'd5
   } csr_index_type;

   function automatic fix_type sat16(input wide_type v);
      if (v > 40'sd32767) begin
         return 16'sh7fff;
      end
      if (v < -40'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   function automatic fix_type addsat(input fix_type a, input fix_type b);
      return sat16(40'(a) + 40'(b));
   endfunction

   function automatic fix_type one_minus(input fix_type x);
      return sat16(40'(ONE) - 40'(x));
   endfunction

   // rounded half up, floor shift, saturate
   function automatic fix_type mulq(input fix_type a, input fix_type b);
      wide_type p;
      p = 40'(a) * 40'(b) + 40'(HALF);
      return sat16(p >>> FRAC_BITS);
   endfunction

   function automatic fix_type intensity(input fix_type r, input fix_type g, input fix_type b);
      wide_type p;
      p = 40'(K_R) * 40'(r) + 40'(K_G) * 40'(g) + 40'(K_B) * 40'(b) + 40'(HALF);
      return sat16(p >>> FRAC_BITS);
   endfunction

endpackage
`default_nettype wire

>>> design/tlb_req_if.sv
`default_nettype none
interface tlb_req_if;
   logic             valid;
   logic             ready;
   tlb_pkg::fix_type tex_red;
   tlb_pkg::fix_type tex_green;
   tlb_pkg::fix_type tex_blue;
   tlb_pkg::fix_type tex_alpha;
   tlb_pkg::fix_type tex_scalar;
   tlb_pkg::fix_type upper_red;
   tlb_pkg::fix_type upper_green;
   tlb_pkg::fix_type upper_blue;
   tlb_pkg::fix_type upper_alpha;
   tlb_pkg::fix_type upper_scalar;

   modport source (
      output valid, tex_red, tex_green, tex_blue, tex_alpha, tex_scalar,
      output upper_red, upper_green, upper_blue, upper_alpha, upper_scalar,
      input  ready
   );
   modport sink (
      input  valid, tex_red, tex_green, tex_blue, tex_alpha, tex_scalar,
      input  upper_red, upper_green, upper_blue, upper_alpha, upper_scalar,
      output ready
   );
endinterface
`default_nettype wire

>>> design/tlb_rsp_if.sv
`default_nettype none
interface tlb_rsp_if;
   logic             valid;
   logic             ready;
   tlb_pkg::fix_type out_red;
   tlb_pkg::fix_type out_green;
   tlb_pkg::fix_type out_blue;
   tlb_pkg::fix_type out_stencil;
   tlb_pkg::fix_type out_value;

   modport source (
      output valid, out_red, out_green, out_blue, out_stencil, out_value,
      input  ready
   );
   modport sink (
      input  valid, out_red, out_green, out_blue, out_stencil, out_value,
      output ready
   );
endinterface
`default_nettype wire

>>> design/tlb_div.sv
`default_nettype none
// Pipelined signed divide: abs/overflow, 8 quotient bits, 8 bits + sign.
// Result is num/den truncated toward zero and saturated; zero when den is zero.
module tlb_div (
   input  logic             clock,
   input  logic             en,
   input  logic [31:0]      num,
   input  tlb_pkg::fix_type den,
   output tlb_pkg::fix_type quo
);
   localparam int STEPS = 8;

   logic [31:0] n_abs;
   logic [15:0] d_abs;

   logic [31:0] a_n_ff;
   logic [15:0] a_d_ff;
   logic        a_neg_ff, a_ovf_ff, a_dz_ff;

   logic [15:0] b_r_ff, b_d_ff;
   logic [7:0]  b_q_ff, b_lo_ff;
   logic        b_neg_ff, b_ovf_ff, b_dz_ff;

   logic [15:0] rb, rc;
   logic [16:0] tb, tc;
   logic [7:0]  qb, qc;
   logic [15:0] qm;
   tlb_pkg::fix_type quo_in, quo_ff;

   always_comb begin
      n_abs = num[31] ? (~num + 32'd1) : num;
      d_abs = den[15] ? (~den + 16'd1) : den;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_n_ff   <= n_abs;
         a_d_ff   <= d_abs;
         a_neg_ff <= num[31] ^ den[15];
         a_ovf_ff <= n_abs >= {d_abs, 16'h0000};
         a_dz_ff  <= d_abs == 16'd0;
      end
   end

   // restoring steps, upper quotient byte
   always_comb begin
      rb = a_n_ff[31:16];
      qb = '0;
      tb = '0;
      for (int i = 0; i < STEPS; i++) begin
         tb = {rb, a_n_ff[15 - i]};
         if (tb >= {1'b0, a_d_ff}) begin
            tb = tb - {1'b0, a_d_ff};
            qb[STEPS - 1 - i] = 1'b1;
         end
         rb = tb[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_r_ff   <= rb;
         b_d_ff   <= a_d_ff;
         b_q_ff   <= qb;
         b_lo_ff  <= a_n_ff[7:0];
         b_neg_ff <= a_neg_ff;
         b_ovf_ff <= a_ovf_ff;
         b_dz_ff  <= a_dz_ff;
      end
   end

   always_comb begin
      rc = b_r_ff;
      qc = '0;
      tc = '0;
      for (int i = 0; i < STEPS; i++) begin
         tc = {rc, b_lo_ff[STEPS - 1 - i]};
         if (tc >= {1'b0, b_d_ff}) begin
            tc = tc - {1'b0, b_d_ff};
            qc[STEPS - 1 - i] = 1'b1;
         end
         rc = tc[15:0];
      end
      qm = {b_q_ff, qc};
      if (b_dz_ff) begin
         quo_in = '0;
      end else if (!b_neg_ff) begin
         quo_in = (b_ovf_ff || qm[15]) ? 16'sh7fff : qm;
      end else begin
         quo_in = (b_ovf_ff || qm > 16'h8000) ? 16'sh8000 : (~qm + 16'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;
endmodule
`default_nettype wire

>>> design/texture_layer_blend.sv
// Texture layer blend: one layer of a texture stack per shading point.
// req_ch carries the texture sample and the upper layer's color, stencil and
// value; rsp_ch returns the blended color, stencil and value. Both are
// valid/ready channels; a request is taken at a clock edge with valid and
// ready high. The csr_ port writes the blend mode, flags, gains and default
// color/value with csr_we; write only while no request is in flight.
// One request is accepted every cycle unless the output stalls; the pipeline
// is ten register stages, the longest paths being one multiply plus a
// saturating add, and the divide mode runs through a three-stage pipelined
// divider alongside the blend math.
// When rsp_ch.ready is low with a response waiting, the whole pipeline holds
// and req_ch.ready drops; nothing is dropped or repeated. The request side
// keeps streaming while ready is high, even with a result waiting at the
// output as long as the receiver takes it in the same cycle.
// Synchronous reset empties the pipeline and loads the register defaults:
// mix mode, flags 72, gains and default value 1.0, default color 1.0 gray.
`default_nettype none
module texture_layer_blend (
   input  logic              clock,
   input  logic              reset,
   tlb_req_if.sink           req_ch,
   tlb_rsp_if.source         rsp_ch,
   input  logic              csr_we,
   input  logic [2:0]        csr_idx,
   input  logic [47:0]       csr_wdata
);
   `include "texture_layer_blend_assert.svh"

   localparam int NSTG = 10;
   localparam int L    = tlb_pkg::LANES;
   localparam int SL   = tlb_pkg::SCALAR_LANE;

   logic [3:0]       blend_mode_ff;
   logic [6:0]       flags_ff;
   tlb_pkg::fix_type color_factor_ff, value_factor_ff, default_value_ff;
   logic [47:0]      default_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_mode_ff    <= 4'd0;
         flags_ff         <= 7'd72;
         color_factor_ff  <= 16'sd4096;
         value_factor_ff  <= 16'sd4096;
         default_value_ff <= 16'sd4096;
         default_color_ff <= 48'h1000_1000_1000;
      end else if (csr_we) begin
         unique case (tlb_pkg::csr_index_type'(csr_idx))
            tlb_pkg::CSR_BLEND_MODE:    blend_mode_ff    <= csr_wdata[3:0];
            tlb_pkg::CSR_CONTROL_FLAGS: flags_ff         <= csr_wdata[6:0];
            tlb_pkg::CSR_COLOR_FACTOR:  color_factor_ff  <= csr_wdata[15:0];
            tlb_pkg::CSR_VALUE_FACTOR:  value_factor_ff  <= csr_wdata[15:0];
            tlb_pkg::CSR_DEFAULT_VALUE: default_value_ff <= csr_wdata[15:0];
            tlb_pkg::CSR_DEFAULT_COLOR: default_color_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic f_neg, f_stencil, f_toint, f_color, f_scalar, f_alpha, f_cin, tex_rgb;
   logic is_sub, is_screen, is_diff;
   tlb_pkg::mode_type md;

   assign f_neg     = flags_ff[tlb_pkg::FL_NEG];
   assign f_stencil = flags_ff[tlb_pkg::FL_STENCIL];
   assign f_toint   = flags_ff[tlb_pkg::FL_TOINT];
   assign f_color   = flags_ff[tlb_pkg::FL_COLOR];
   assign f_scalar  = flags_ff[tlb_pkg::FL_SCALAR];
   assign f_alpha   = flags_ff[tlb_pkg::FL_ALPHA];
   assign f_cin     = flags_ff[tlb_pkg::FL_CIN];
   assign tex_rgb   = f_cin && !f_toint;
   assign md        = tlb_pkg::mode_type'(blend_mode_ff);
   assign is_sub    = md == tlb_pkg::MODE_SUBTRACT;
   assign is_screen = md == tlb_pkg::MODE_SCREEN;
   assign is_diff   = md == tlb_pkg::MODE_DIFFERENCE;

   // global stall: every stage moves when the output slot is free or taken
   logic            en;
   logic [NSTG-1:0] vld_ff;

   assign en           = !vld_ff[NSTG-1] || rsp_ch.ready;
   assign req_ch.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTG-2:0], req_ch.valid};
      end
   end

   // S1: select texture alpha, invert color channels
   tlb_pkg::fix_type s1_tc_ff [3];
   tlb_pkg::fix_type s1_o_ff [L];
   tlb_pkg::fix_type s1_ta_ff, s1_ts_ff, s1_st_ff;
   tlb_pkg::fix_type tc_in [3];

   assign tc_in[0] = req_ch.tex_red;
   assign tc_in[1] = req_ch.tex_green;
   assign tc_in[2] = req_ch.tex_blue;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s1_tc_ff[i] <= (tex_rgb && f_neg) ? tlb_pkg::one_minus(tc_in[i]) : tc_in[i];
         end
         s1_ta_ff <= f_cin ? req_ch.tex_alpha : tlb_pkg::sat16(40'(tlb_pkg::ONE));
         s1_ts_ff <= req_ch.tex_scalar;
         s1_st_ff <= req_ch.upper_alpha;
         s1_o_ff[0] <= req_ch.upper_red;
         s1_o_ff[1] <= req_ch.upper_green;
         s1_o_ff[2] <= req_ch.upper_blue;
         s1_o_ff[SL] <= req_ch.upper_scalar;
      end
   end

   // S2: intensity (raw for rgb_to_int, inverted for the scalar path)
   tlb_pkg::fix_type s2_tc_ff [3];
   tlb_pkg::fix_type s2_o_ff [L];
   tlb_pkg::fix_type s2_int_ff, s2_ta_ff, s2_ts_ff, s2_st_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s2_int_ff <= tlb_pkg::intensity(s1_tc_ff[0], s1_tc_ff[1], s1_tc_ff[2]);
         s2_tc_ff  <= s1_tc_ff;
         s2_o_ff   <= s1_o_ff;
         s2_ta_ff  <= s1_ta_ff;
         s2_ts_ff  <= s1_ts_ff;
         s2_st_ff  <= s1_st_ff;
      end
   end

   // S3: negative on intensity, stencil product
   tlb_pkg::fix_type s3_tc_ff [3];
   tlb_pkg::fix_type s3_o_ff [L];
   tlb_pkg::fix_type s3_int_ff, s3_ta_ff, s3_tin_ff, s3_st_ff;
   tlb_pkg::fix_type tin_raw, tin_n, sfact, sprod;

   always_comb begin
      tin_raw = f_cin ? s2_int_ff : s2_ts_ff;
      tin_n   = f_neg ? tlb_pkg::one_minus(tin_raw) : tin_raw;
      sfact   = tex_rgb ? s2_ta_ff : tin_n;
      sprod   = tlb_pkg::mulq(s2_st_ff, sfact);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_st_ff  <= f_stencil ? sprod : s2_st_ff;
         s3_ta_ff  <= (f_stencil && tex_rgb) ? sprod : s2_ta_ff;
         s3_tin_ff <= (f_stencil && !tex_rgb) ? sprod : tin_n;
         s3_int_ff <= s2_int_ff;
         s3_tc_ff  <= s2_tc_ff;
         s3_o_ff   <= s2_o_ff;
      end
   end

   // S4: gains, blend factors and lane operands
   tlb_pkg::fix_type s4_t_ff [L];
   tlb_pkg::fix_type s4_o_ff [L];
   tlb_pkg::fix_type s4_fact_ff [L];
   tlb_pkg::fix_type s4_g_ff [L];
   tlb_pkg::fix_type s4_st_ff;
   tlb_pkg::fix_type gc, gv, factc, factv, ta_n;
   tlb_pkg::fix_type dcol [3];

   assign dcol[0] = default_color_ff[47:32];
   assign dcol[1] = default_color_ff[31:16];
   assign dcol[2] = default_color_ff[15:0];

   always_comb begin
      gc    = tlb_pkg::mulq(s3_st_ff, color_factor_ff);
      gv    = tlb_pkg::mulq(s3_st_ff, value_factor_ff);
      ta_n  = f_neg ? tlb_pkg::one_minus(s3_ta_ff) : s3_ta_ff;
      factc = tex_rgb ? s3_ta_ff : s3_tin_ff;
      factv = tex_rgb ? (f_alpha ? ta_n : s3_int_ff) : s3_tin_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s4_t_ff[i]    <= tex_rgb ? s3_tc_ff[i] : dcol[i];
            s4_fact_ff[i] <= factc;
            s4_g_ff[i]    <= gc;
         end
         s4_t_ff[SL]    <= default_value_ff;
         s4_fact_ff[SL] <= factv;
         s4_g_ff[SL]    <= gv;
         s4_o_ff        <= s3_o_ff;
         s4_st_ff       <= s3_st_ff;
      end
   end

   // S5: f, subtract factor, 1 - g
   tlb_pkg::fix_type s5_f_ff [L];
   tlb_pkg::fix_type s5_sf_ff [L];
   tlb_pkg::fix_type s5_gm_ff [L];
   tlb_pkg::fix_type s5_t_ff [L];
   tlb_pkg::fix_type s5_o_ff [L];
   tlb_pkg::fix_type s5_st_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < L; i++) begin
            s5_f_ff[i]  <= tlb_pkg::mulq(s4_fact_ff[i], s4_g_ff[i]);
            s5_sf_ff[i] <= tlb_pkg::mulq(tlb_pkg::sat16(-40'(s4_fact_ff[i])), s4_g_ff[i]);
            s5_gm_ff[i] <= tlb_pkg::one_minus(s4_g_ff[i]);
         end
         s5_t_ff  <= s4_t_ff;
         s5_o_ff  <= s4_o_ff;
         s5_st_ff <= s4_st_ff;
      end
   end

   // S6: first product, difference, divide numerator
   tlb_pkg::fix_type s6_f_ff [L];
   tlb_pkg::fix_type s6_fm_ff [L];
   tlb_pkg::fix_type s6_gm_ff [L];
   tlb_pkg::fix_type s6_m1_ff [L];
   tlb_pkg::fix_type s6_d_ff [L];
   tlb_pkg::fix_type s6_t_ff [L];
   tlb_pkg::fix_type s6_o_ff [L];
   logic [31:0]      s6_num_ff [L];
   tlb_pkg::fix_type s6_st_ff;
   tlb_pkg::fix_type dif [L];

   always_comb begin
      for (int i = 0; i < L; i++) begin
         dif[i] = tlb_pkg::sat16(40'(s5_t_ff[i]) - 40'(s5_o_ff[i]));
         dif[i] = dif[i][15] ? tlb_pkg::sat16(-40'(dif[i])) : dif[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < L; i++) begin
            s6_fm_ff[i]  <= tlb_pkg::one_minus(s5_f_ff[i]);
            s6_m1_ff[i]  <= tlb_pkg::mulq(
                               is_screen ? tlb_pkg::one_minus(s5_t_ff[i]) : s5_t_ff[i],
                               is_sub ? s5_sf_ff[i] : s5_f_ff[i]);
            s6_num_ff[i] <= 32'(s5_f_ff[i]) * 32'(s5_o_ff[i]);
            s6_d_ff[i]   <= dif[i];
         end
         s6_f_ff  <= s5_f_ff;
         s6_gm_ff <= s5_gm_ff;
         s6_t_ff  <= s5_t_ff;
         s6_o_ff  <= s5_o_ff;
         s6_st_ff <= s5_st_ff;
      end
   end

   // divider lanes, result lines up with S9
   tlb_pkg::fix_type quo [L];

   for (genvar g = 0; g < L; g++) begin : g_div
      tlb_div u_div (
         .clock (clock),
         .en    (en),
         .num   (s6_num_ff[g]),
         .den   (s6_t_ff[g]),
         .quo   (quo[g])
      );
   end

   // S7: second products
   tlb_pkg::fix_type s7_m1_ff [L];
   tlb_pkg::fix_type s7_ma_ff [L];
   tlb_pkg::fix_type s7_mb_ff [L];
   tlb_pkg::fix_type s7_o_ff [L];
   logic [L-1:0]     s7_tz_ff;
   tlb_pkg::fix_type s7_st_ff;
   tlb_pkg::fix_type mx [L];
   tlb_pkg::fix_type my [L];

   always_comb begin
      for (int i = 0; i < L; i++) begin
         mx[i] = is_diff ? s6_f_ff[i] : tlb_pkg::addsat(s6_gm_ff[i], s6_m1_ff[i]);
         my[i] = is_diff ? s6_d_ff[i]
                 : (is_screen ? tlb_pkg::one_minus(s6_o_ff[i]) : s6_o_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < L; i++) begin
            s7_ma_ff[i] <= tlb_pkg::mulq(s6_fm_ff[i], s6_o_ff[i]);
            s7_mb_ff[i] <= tlb_pkg::mulq(mx[i], my[i]);
            s7_tz_ff[i] <= s6_t_ff[i] == 16'sd0;
         end
         s7_m1_ff <= s6_m1_ff;
         s7_o_ff  <= s6_o_ff;
         s7_st_ff <= s6_st_ff;
      end
   end

   // S8, S9: wait for the divider
   tlb_pkg::fix_type s8_m1_ff [L];
   tlb_pkg::fix_type s8_ma_ff [L];
   tlb_pkg::fix_type s8_mb_ff [L];
   tlb_pkg::fix_type s8_o_ff [L];
   logic [L-1:0]     s8_tz_ff;
   tlb_pkg::fix_type s8_st_ff;
   tlb_pkg::fix_type s9_m1_ff [L];
   tlb_pkg::fix_type s9_ma_ff [L];
   tlb_pkg::fix_type s9_mb_ff [L];
   tlb_pkg::fix_type s9_o_ff [L];
   logic [L-1:0]     s9_tz_ff;
   tlb_pkg::fix_type s9_st_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s8_m1_ff <= s7_m1_ff;
         s8_ma_ff <= s7_ma_ff;
         s8_mb_ff <= s7_mb_ff;
         s8_o_ff  <= s7_o_ff;
         s8_tz_ff <= s7_tz_ff;
         s8_st_ff <= s7_st_ff;
         s9_m1_ff <= s8_m1_ff;
         s9_ma_ff <= s8_ma_ff;
         s9_mb_ff <= s8_mb_ff;
         s9_o_ff  <= s8_o_ff;
         s9_tz_ff <= s8_tz_ff;
         s9_st_ff <= s8_st_ff;
      end
   end

   // final combine, clamp at zero, select against upper values
   tlb_pkg::fix_type res [L];
   tlb_pkg::fix_type outv [L];

   always_comb begin
      for (int i = 0; i < L; i++) begin
         case (md) inside
            tlb_pkg::MODE_ADD, tlb_pkg::MODE_SUBTRACT:
               res[i] = tlb_pkg::addsat(s9_m1_ff[i], s9_o_ff[i]);
            tlb_pkg::MODE_MULTIPLY:   res[i] = s9_mb_ff[i];
            tlb_pkg::MODE_SCREEN:     res[i] = tlb_pkg::one_minus(s9_mb_ff[i]);
            tlb_pkg::MODE_DIVIDE:
               res[i] = (i == SL && s9_tz_ff[i]) ? 16'sd0
                        : tlb_pkg::addsat(s9_ma_ff[i], quo[i]);
            tlb_pkg::MODE_DIFFERENCE: res[i] = tlb_pkg::addsat(s9_ma_ff[i], s9_mb_ff[i]);
            tlb_pkg::MODE_DARKEN:
               res[i] = (s9_m1_ff[i] < s9_o_ff[i]) ? s9_m1_ff[i] : s9_o_ff[i];
            tlb_pkg::MODE_LIGHTEN:
               res[i] = (s9_m1_ff[i] > s9_o_ff[i]) ? s9_m1_ff[i] : s9_o_ff[i];
            default:                  res[i] = tlb_pkg::addsat(s9_m1_ff[i], s9_ma_ff[i]);
         endcase
         if (res[i][15]) begin
            res[i] = '0;
         end
         outv[i] = ((i == SL) ? f_scalar : f_color) ? res[i] : s9_o_ff[i];
      end
   end

   tlb_pkg::fix_type out_r_ff, out_g_ff, out_b_ff, out_st_ff, out_v_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         out_r_ff  <= outv[0];
         out_g_ff  <= outv[1];
         out_b_ff  <= outv[2];
         out_v_ff  <= outv[SL];
         out_st_ff <= s9_st_ff;
      end
   end

   assign rsp_ch.valid       = vld_ff[NSTG-1];
   assign rsp_ch.out_red     = out_r_ff;
   assign rsp_ch.out_green   = out_g_ff;
   assign rsp_ch.out_blue    = out_b_ff;
   assign rsp_ch.out_stencil = out_st_ff;
   assign rsp_ch.out_value   = out_v_ff;

   logic color_neg;

   assign color_neg = out_r_ff[15] || out_g_ff[15] || out_b_ff[15];

   `TLB_ASSERT_NEXT(a_stall_hold, clock, reset, !en, $stable(vld_ff))
   `TLB_ASSERT_NEXT(a_enter, clock, reset, en && req_ch.valid, vld_ff[0])
   `TLB_ASSERT(a_color_clamp, clock, reset, !(rsp_ch.valid && f_color) || !color_neg)
   `TLB_ASSERT(a_value_clamp, clock, reset, !(rsp_ch.valid && f_scalar) || !out_v_ff[15])
endmodule
`default_nettype wire
